[design/sre_pkg.sv]
package sre_pkg;

    // Fixed field widths of the command and result words.
    localparam int IDX_BITS = 4;
    localparam int LEN_BITS = IDX_BITS + 1;
    localparam int AMT_BITS = 8;
    localparam int VAL_BITS = 32;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_ROT_RIGHT = 2'd2,
        OP_ROT_LEFT  = 2'd3
    } t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic mod_init;
        logic mod_step;
        logic rot_init;
        logic wr_word;
        logic rd_word;
        logic rd_seg;
        logic cap_word;
        logic mv_write;
        logic res_ok;
        logic res_err;
        logic res_read;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode op;
        logic    range_err;
        logic    clr_last;
        logic    mod_last;
        logic    m_zero;
        logic    cycle_closed;
        logic    moves_last;
    } t_dp_stat;

endpackage

[design/sre_ram.sv]
module sre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sre_dp.sv]
module sre_dp
    import sre_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic [1:0]                 i_opcode,
    input  logic [IDX_BITS-1:0]        i_word_index,
    input  logic signed [VAL_BITS-1:0] i_write_value,
    input  logic [IDX_BITS-1:0]        i_seg_start,
    input  logic [IDX_BITS-1:0]        i_seg_end,
    input  logic [AMT_BITS-1:0]        i_shift_amount,
    output logic signed [VAL_BITS-1:0] o_read_data,
    output logic                       o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(AMT_BITS);

    // Latched command word.
    t_opcode               r_op;
    logic [IDX_BITS-1:0]   r_idx;
    logic [WORD_BITS-1:0]  r_val;
    logic [IDX_BITS-1:0]   r_seg_s;
    logic [IDX_BITS-1:0]   r_seg_e;
    logic [AMT_BITS-1:0]   r_kshift;

    // Modulo unit, rotation walker and clearing counter.
    logic [IDX_BITS-1:0]   r_rem;
    logic [BW-1:0]         r_bcnt;
    logic [IDX_BITS-1:0]   r_mr;
    logic [IDX_BITS-1:0]   r_pos;
    logic [IDX_BITS-1:0]   r_cstart;
    logic [LEN_BITS-1:0]   r_cnt;
    logic [WORD_BITS-1:0]  r_word;
    logic [AW-1:0]         r_clr_addr;

    // Result registers.
    logic [VAL_BITS-1:0]   r_read_data;
    logic                  r_status;

    logic [63:0]           ext_val;
    logic [63:0]           ext_rd;
    logic [LEN_BITS-1:0]   len_w;
    logic [LEN_BITS-1:0]   trial;
    logic [IDX_BITS-1:0]   n_rem;
    logic [IDX_BITS-1:0]   n_mr;
    logic [LEN_BITS-1:0]   dest_sum;
    logic [IDX_BITS-1:0]   dest_w;
    logic [IDX_BITS-1:0]   seg_addr;
    logic                  idx_oob;
    logic                  seg_err;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [WORD_BITS-1:0]  ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [WORD_BITS-1:0]  ram_rd_data;

    // The incoming word is sign extended, then kept at the store width.
    assign ext_val = {{(64 - VAL_BITS){i_write_value[VAL_BITS-1]}}, i_write_value};
    assign ext_rd  = 64'(ram_rd_data);

    // Segment length and range checks.
    assign len_w   = LEN_BITS'({1'b0, r_seg_e} - {1'b0, r_seg_s} + LEN_BITS'(1));
    assign idx_oob = 32'(r_idx) >= 32'(DEPTH);
    assign seg_err = (r_seg_s > r_seg_e) || (32'(r_seg_e) >= 32'(DEPTH));

    // One restoring division step per cycle, most significant bit first.
    assign trial = {r_rem, r_kshift[AMT_BITS-1]};
    assign n_rem = (trial >= len_w) ? IDX_BITS'(trial - len_w) : trial[IDX_BITS-1:0];

    // A left rotation is a right rotation by the complement.
    assign n_mr = (r_op == OP_ROT_RIGHT) ? r_rem
                                         : IDX_BITS'(len_w - LEN_BITS'(r_rem));

    // Next position of the current cycle, wrapped into the segment.
    assign dest_sum = LEN_BITS'(r_pos) + LEN_BITS'(r_mr);
    assign dest_w   = (dest_sum >= len_w) ? IDX_BITS'(dest_sum - len_w)
                                          : dest_sum[IDX_BITS-1:0];
    assign seg_addr = r_seg_s + r_pos;

    // Status back to the controller.
    always_comb begin
        o_stat.op           = r_op;
        o_stat.range_err    = ((r_op == OP_WRITE) || (r_op == OP_READ)) ? idx_oob : seg_err;
        o_stat.clr_last     = r_clr_addr == AW'(DEPTH - 1);
        o_stat.mod_last     = r_bcnt == BW'(AMT_BITS - 1);
        o_stat.m_zero       = r_rem == '0;
        o_stat.cycle_closed = r_pos == r_cstart;
        o_stat.moves_last   = LEN_BITS'(r_cnt + LEN_BITS'(1)) == len_w;
    end

    // Store port selection.
    always_comb begin
        ram_wr_en   = i_cmd.clr_step | i_cmd.wr_word | i_cmd.mv_write;
        ram_wr_addr = AW'(r_idx);
        ram_wr_data = r_val;
        if (i_cmd.clr_step) begin
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else if (i_cmd.mv_write) begin
            ram_wr_addr = AW'(seg_addr);
            ram_wr_data = r_word;
        end
        ram_rd_en   = i_cmd.rd_word | i_cmd.rd_seg;
        ram_rd_addr = i_cmd.rd_word ? AW'(r_idx) : AW'(seg_addr);
    end

    sre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Command word and working payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_opcode'(i_opcode);
            r_idx    <= i_word_index;
            r_val    <= ext_val[WORD_BITS-1:0];
            r_seg_s  <= i_seg_start;
            r_seg_e  <= i_seg_end;
            r_kshift <= i_shift_amount;
        end else if (i_cmd.mod_step) begin
            r_kshift <= r_kshift << 1;
        end
        if (i_cmd.rot_init) begin
            r_mr <= n_mr;
        end
        if (i_cmd.cap_word || i_cmd.mv_write) begin
            r_word <= ram_rd_data;
        end
    end

    // Control counters of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rem      <= '0;
            r_bcnt     <= '0;
            r_pos      <= '0;
            r_cstart   <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.mod_init) begin
                r_rem  <= '0;
                r_bcnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_rem  <= n_rem;
                r_bcnt <= r_bcnt + BW'(1);
            end
            if (i_cmd.rot_init) begin
                r_pos    <= '0;
                r_cstart <= '0;
                r_cnt    <= '0;
            end else if (i_cmd.cap_word) begin
                r_pos <= dest_w;
            end else if (i_cmd.mv_write) begin
                r_cnt <= LEN_BITS'(r_cnt + LEN_BITS'(1));
                if (r_pos == r_cstart) begin
                    r_cstart <= r_cstart + IDX_BITS'(1);
                    r_pos    <= r_cstart + IDX_BITS'(1);
                end else begin
                    r_pos <= dest_w;
                end
            end
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_read) begin
            r_read_data <= ext_rd[VAL_BITS-1:0];
            r_status    <= STATUS_OK;
        end else if (i_cmd.res_ok) begin
            r_read_data <= '0;
            r_status    <= STATUS_OK;
        end else if (i_cmd.res_err) begin
            r_read_data <= '0;
            r_status    <= STATUS_ERR;
        end
    end

    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

[design/sre_ctrl.sv]
module sre_ctrl
    import sre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output logic     o_done,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_ROT_INIT,
        S_LOAD_RD,
        S_LOAD_CAP,
        S_MV_RD,
        S_MV_WR,
        S_RD_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_done;
    logic   n_done;

    // Next state, registered outputs and datapath commands.
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                    n_busy     = 1'b1;
                end
            end
            S_DECODE: begin
                if (i_stat.range_err) begin
                    o_cmd.res_err = 1'b1;
                    n_done        = 1'b1;
                    n_busy        = 1'b0;
                    n_state       = S_IDLE;
                end else begin
                    case (i_stat.op)
                        OP_WRITE: begin
                            o_cmd.wr_word = 1'b1;
                            o_cmd.res_ok  = 1'b1;
                            n_done        = 1'b1;
                            n_busy        = 1'b0;
                            n_state       = S_IDLE;
                        end
                        OP_READ: begin
                            o_cmd.rd_word = 1'b1;
                            n_state       = S_RD_WAIT;
                        end
                        default: begin
                            o_cmd.mod_init = 1'b1;
                            n_state        = S_MOD;
                        end
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_ROT_INIT;
                end
            end
            S_ROT_INIT: begin
                if (i_stat.m_zero) begin
                    o_cmd.res_ok = 1'b1;
                    n_done       = 1'b1;
                    n_busy       = 1'b0;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rot_init = 1'b1;
                    n_state        = S_LOAD_RD;
                end
            end
            S_LOAD_RD: begin
                o_cmd.rd_seg = 1'b1;
                n_state      = S_LOAD_CAP;
            end
            S_LOAD_CAP: begin
                o_cmd.cap_word = 1'b1;
                n_state        = S_MV_RD;
            end
            S_MV_RD: begin
                o_cmd.rd_seg = 1'b1;
                n_state      = S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.mv_write = 1'b1;
                if (i_stat.moves_last) begin
                    o_cmd.res_ok = 1'b1;
                    n_done       = 1'b1;
                    n_busy       = 1'b0;
                    n_state      = S_IDLE;
                end else if (i_stat.cycle_closed) begin
                    n_state = S_LOAD_RD;
                end else begin
                    n_state = S_MV_RD;
                end
            end
            S_RD_WAIT: begin
                o_cmd.res_read = 1'b1;
                n_done         = 1'b1;
                n_busy         = 1'b0;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // State and registered outputs; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

[design/segment_rotate_engine_core.sv]
// Writes and errors are answered from the decode state; reads also pass a read wait state.
// Rotations: a bit-serial modulo unit takes the amount modulo the segment length, then
// the store is walked through its single read and write ports, with a read and a write per
// moved word plus a read and a capture per rotation cycle; nothing moves when the turn is zero.
// Handshake: busy is low in the strobe cycle, so the next word can be taken as it ends.
// After reset the store is cleared to zero one word a cycle, with busy high until the last is cleared.
module segment_rotate_engine_core
    import sre_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_opcode,
    input  logic [IDX_BITS-1:0]        i_word_index,
    input  logic signed [VAL_BITS-1:0] i_write_value,
    input  logic [IDX_BITS-1:0]        i_seg_start,
    input  logic [IDX_BITS-1:0]        i_seg_end,
    input  logic [AMT_BITS-1:0]        i_shift_amount,
    output logic                       o_done,
    output logic signed [VAL_BITS-1:0] o_read_data,
    output logic                       o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    sre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Store, modulo unit and rotation walker.
    sre_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_write_value  (i_write_value),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_shift_amount (i_shift_amount),
        .o_read_data    (o_read_data),
        .o_status       (o_status)
    );

endmodule

[design/sre_checker.sv]
module sre_checker
    import sre_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic signed [VAL_BITS-1:0] o_read_data,
    input logic                       o_status
);

    // A result word is only shown once the engine is free again.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted word makes the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // Every result follows a busy period.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // Results never come in consecutive cycles.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An error result carries zero data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STATUS_ERR)) |-> (o_read_data == '0))
        else $error("error result with nonzero data");

endmodule

bind segment_rotate_engine_core sre_checker u_sre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_read_data (o_read_data),
    .o_status    (o_status)
);

[bench/segment_rotate_engine_core_tb.sv]
module segment_rotate_engine_core_tb;
    import sre_pkg::*;

    localparam int STORE_DEPTH = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 80;

    // One expected result word.
    typedef struct {
        logic signed [VAL_BITS-1:0] data;
        logic                       status;
    } t_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_opcode;
    logic [IDX_BITS-1:0]        i_word_index;
    logic signed [VAL_BITS-1:0] i_write_value;
    logic [IDX_BITS-1:0]        i_seg_start;
    logic [IDX_BITS-1:0]        i_seg_end;
    logic [AMT_BITS-1:0]        i_shift_amount;
    logic                       o_done;
    logic signed [VAL_BITS-1:0] o_read_data;
    logic                       o_status;

    // Shadow copy of the word store and results still owed by the block.
    logic [VAL_BITS-1:0] shadow_store [STORE_DEPTH];
    t_result             owed_results [$];
    int                  error_count = 0;
    int                  stall_cycles = 0;
    int                  sender_idle_pct = 0;
    bit                  start_level = 1'b0;

    segment_rotate_engine_core #(
        .DEPTH     (STORE_DEPTH),
        .WORD_BITS (VAL_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_write_value  (i_write_value),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_shift_amount (i_shift_amount),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_status       (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Apply one command to the shadow store and return the word it should produce.
    function automatic t_result apply_command(t_opcode op, logic [IDX_BITS-1:0] idx,
                                              logic [VAL_BITS-1:0] val,
                                              logic [IDX_BITS-1:0] seg_lo,
                                              logic [IDX_BITS-1:0] seg_hi,
                                              logic [AMT_BITS-1:0] amt);
        t_result             res;
        int                  seg_len;
        int                  turn;
        logic [VAL_BITS-1:0] held [STORE_DEPTH];
        res.data   = '0;
        res.status = STATUS_OK;
        if (op == OP_WRITE || op == OP_READ) begin
            if (int'(idx) >= STORE_DEPTH) begin
                res.status = STATUS_ERR;
            end else if (op == OP_WRITE) begin
                shadow_store[idx] = val;
            end else begin
                res.data = shadow_store[idx];
            end
        end else if (seg_lo > seg_hi || int'(seg_hi) >= STORE_DEPTH) begin
            res.status = STATUS_ERR;
        end else begin
            seg_len = int'(seg_hi) - int'(seg_lo) + 1;
            turn = int'(amt) % seg_len;
            // A left turn is the right turn by the complement.
            if (op == OP_ROT_LEFT && turn != 0) begin
                turn = seg_len - turn;
            end
            for (int k = 0; k < seg_len; k++) begin
                held[(k + turn) % seg_len] = shadow_store[int'(seg_lo) + k];
            end
            for (int k = 0; k < seg_len; k++) begin
                shadow_store[int'(seg_lo) + k] = held[k];
            end
        end
        return res;
    endfunction

    // Offer one command word and hold it until the block takes it. Called and
    // returns in the time step of a rising edge.
    task automatic send_word(t_opcode op, logic [IDX_BITS-1:0] idx,
                             logic [VAL_BITS-1:0] val, logic [IDX_BITS-1:0] seg_lo,
                             logic [IDX_BITS-1:0] seg_hi, logic [AMT_BITS-1:0] amt);
        start          <= 1'b1;
        start_level     = 1'b1;
        i_opcode       <= op;
        i_word_index   <= idx;
        i_write_value  <= val;
        i_seg_start    <= seg_lo;
        i_seg_end      <= seg_hi;
        i_shift_amount <= amt;
        do begin
            @(posedge i_clk);
        end while (busy);
        owed_results.push_back(apply_command(op, idx, val, seg_lo, seg_hi, amt));
        // Optional gap before the next word.
        if ($urandom_range(99) < sender_idle_pct) begin
            start      <= 1'b0;
            start_level = 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        if (start_level) begin
            start      <= 1'b0;
            start_level = 1'b0;
        end
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Reads right after reset must see the cleared store.
    task automatic test_after_reset();
        send_word(OP_READ, 4'd0, '0, 4'd0, 4'd0, 8'd0);
        send_word(OP_READ, 4'd15, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // Extreme values at the extreme positions.
    task automatic test_write_read_extremes();
        send_word(OP_WRITE, 4'd0, 32'h8000_0000, 4'd0, 4'd0, 8'd0);
        send_word(OP_WRITE, 4'd15, 32'h7FFF_FFFF, 4'd0, 4'd0, 8'd0);
        send_word(OP_WRITE, 4'd1, 32'hFFFF_FFFF, 4'd0, 4'd0, 8'd0);
        send_word(OP_WRITE, 4'd2, 32'h0000_0001, 4'd0, 4'd0, 8'd0);
        send_word(OP_READ, 4'd15, '0, 4'd0, 4'd0, 8'd0);
        send_word(OP_READ, 4'd0, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // One-step turns of the whole store in both directions.
    task automatic test_one_step_rotations();
        send_word(OP_ROT_RIGHT, 4'd0, '0, 4'd0, 4'd15, 8'd1);
        send_word(OP_READ, 4'd0, '0, 4'd0, 4'd0, 8'd0);
        send_word(OP_ROT_LEFT, 4'd0, '0, 4'd0, 4'd15, 8'd1);
        send_word(OP_ROT_LEFT, 4'd0, '0, 4'd0, 4'd15, 8'd1);
        send_word(OP_READ, 4'd15, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // Turns that move nothing: single words, zero and whole multiples of the length.
    task automatic test_zero_rotations();
        send_word(OP_ROT_RIGHT, 4'd0, '0, 4'd3, 4'd3, 8'd255);
        send_word(OP_ROT_LEFT, 4'd0, '0, 4'd0, 4'd15, 8'd0);
        send_word(OP_ROT_RIGHT, 4'd0, '0, 4'd0, 4'd15, 8'd16);
        send_word(OP_READ, 4'd1, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // Large amounts on inner segments.
    task automatic test_wide_rotations();
        send_word(OP_ROT_RIGHT, 4'd0, '0, 4'd0, 4'd9, 8'd255);
        send_word(OP_ROT_LEFT, 4'd0, '0, 4'd5, 4'd14, 8'd200);
        send_word(OP_READ, 4'd6, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // Reversed segments report an error and leave the store alone.
    task automatic test_segment_errors();
        send_word(OP_ROT_RIGHT, 4'd0, '0, 4'd9, 4'd4, 8'd3);
        send_word(OP_ROT_LEFT, 4'd0, '0, 4'd15, 4'd0, 8'd1);
        send_word(OP_READ, 4'd9, '0, 4'd0, 4'd0, 8'd0);
    endtask

    // Random mix: mostly valid segments, a few broken ones, all fields random.
    task automatic test_random(int count, int idle_pct);
        int               pick;
        t_opcode          op;
        logic [IDX_BITS-1:0] seg_lo;
        logic [IDX_BITS-1:0] seg_hi;
        logic [AMT_BITS-1:0] amt;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = t_opcode'((pick < 25) ? OP_WRITE : (pick < 50) ? OP_READ :
                           (pick < 75) ? OP_ROT_RIGHT : OP_ROT_LEFT);
            if ($urandom_range(9) == 0) begin
                seg_lo = IDX_BITS'($urandom_range(15));
                seg_hi = IDX_BITS'($urandom_range(15));
            end else begin
                seg_lo = IDX_BITS'($urandom_range(15));
                seg_hi = IDX_BITS'($urandom_range(15, seg_lo));
            end
            if ($urandom_range(99) < 40) begin
                amt = AMT_BITS'($urandom_range(255));
            end else begin
                amt = AMT_BITS'($urandom_range(2 * (int'(seg_hi) - int'(seg_lo) + 1), 0));
            end
            send_word(op, IDX_BITS'($urandom_range(15)), $urandom, seg_lo, seg_hi, amt);
        end
    endtask

    // Compare each result word with the oldest owed one.
    always @(posedge i_clk) begin
        t_result want;
        if (o_done === 1'b1) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result data=%h status=%b", $time,
                         o_read_data, o_status);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_read_data !== want.data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.data, o_read_data);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %b actual %b", $time,
                             want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Give up when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL segment_rotate_engine_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_WRITE;
        i_word_index   = '0;
        i_write_value  = '0;
        i_seg_start    = '0;
        i_seg_end      = '0;
        i_shift_amount = '0;
        foreach (shadow_store[k]) shadow_store[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_write_read_extremes();
        test_one_step_rotations();
        test_zero_rotations();
        test_wide_rotations();
        test_segment_errors();
        drain_results();

        test_random(130, 23);
        drain_results();
        test_random(130, 63);
        test_random(140, 0);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && owed_results.size() == 0) begin
            $display("PASS segment_rotate_engine_core");
        end else begin
            $display("FAIL segment_rotate_engine_core");
        end
        $finish;
    end

endmodule

[segment_rotate_engine_core.f]
design/sre_pkg.sv
design/sre_ram.sv
design/sre_dp.sv
design/sre_ctrl.sv
design/segment_rotate_engine_core.sv
design/sre_checker.sv
bench/segment_rotate_engine_core_tb.sv
